/* sv/a2u_pkg.sv */
// Shared types and constants for the ASCII to unsigned converter.
package a2u_pkg;

	// Character class, as built by the front and consumed by the back
	typedef struct packed {
		logic       nul;
		logic       ws;
		logic       plus;
		logic       minus;
		logic       zero;
		logic       x;
		logic       hex;
		logic [5:0] digit;
	} cls_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_BITS   = 1;
	localparam int unsigned QCNT_BITS   = 2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_DIGITS = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_BAD_BASE  = 2'd3;

	localparam logic [5:0] BASE_AUTO  = 6'd0;
	localparam logic [5:0] BASE_ONE   = 6'd1;
	localparam logic [5:0] BASE_OCT   = 6'd8;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_HEX   = 6'd16;
	localparam logic [5:0] BASE_MAX   = 6'd36;
	localparam logic [5:0] BASE_RESET = 6'd10;
	localparam logic [5:0] NO_DIGIT   = 6'd63;

endpackage

/* sv/ascii_to_unsigned_converter.sv */
// Top level of the streaming ASCII to unsigned integer converter.
//
// Usage: send one string byte per request on in_valid/in_ready (character);
// a zero byte ends the string. Every string yields exactly one result on
// out_valid/out_ready: value, end_index and status (0 ok, 1 no digits,
// 2 overflow, 3 invalid base). The result leaves at the byte that ends the
// number; later bytes up to the zero byte produce nothing.
// number_base is written through cfg_we/cfg_wdata and is sampled at the first
// byte of each string; write it only while the block is idle.
// Throughput: one byte per cycle while the receiver takes results, set by the
// single multiply-add of the accumulator in the back end. An accepted byte is
// written into the queue, read from its head by the back end, and the result
// register then loads from it and raises out_valid.
// When the receiver stalls, the result register holds and the back end stops;
// the front keeps taking bytes until the two-entry queue is full, then drops
// in_ready.
// Reset clears the parse state, the queue and the result register, and sets
// number_base to 10. No clearing pass is needed.
module ascii_to_unsigned_converter #(
	parameter int unsigned VALUE_BITS    = 32,
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic [15:0] end_index,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);

	localparam logic [63:0] VMASK_W = (VALUE_BITS >= 64) ? '1 :
		((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [31:0] SAT_OUT = VMASK_W[31:0];

	logic [5:0]         number_base_q;
	logic               q_full;
	logic               q_push;
	a2u_pkg::cls_t      q_in;
	logic               q_pop;
	logic               q_valid;
	a2u_pkg::cls_t      q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= a2u_pkg::BASE_RESET;
		end else if (cfg_we) begin
			number_base_q <= cfg_wdata;
		end
	end

	a2u_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	a2u_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	a2u_back #(
		.VALUE_BITS    (VALUE_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_base (number_base_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.end_index   (end_index),
		.status      (status)
	);

	a_bad_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == a2u_pkg::ST_BAD_BASE)) |-> ((value == '0) && (end_index == '0)))
		else $error("invalid base result carries a value or index");

	a_no_digits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == a2u_pkg::ST_NO_DIGITS)) |-> ((value == '0) && (end_index == '0)))
		else $error("no-digit result carries a value or index");

	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == a2u_pkg::ST_OVERFLOW)) |-> ((value == SAT_OUT) || (value == 32'd1)))
		else $error("overflow result is not saturated");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready) |=> (in_ready || !$stable(out_ready) || !out_ready || $past(!out_valid)))
		else $error("queue stays full while results drain");

endmodule

/* sv/a2u_front.sv */
// Front end: accepts characters and classifies them for the parser.
module a2u_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       character,
	input  logic             q_full,
	output logic             q_push,
	output a2u_pkg::cls_t    q_data
);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] OFS_UPPER = 8'h37;
	localparam logic [7:0] OFS_LOWER = 8'h57;

	logic       is_num;
	logic       is_upper;
	logic       is_lower;
	logic [7:0] dval;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		is_num   = (character >= CH_0) && (character <= CH_9);
		is_upper = (character >= CH_UA) && (character <= CH_UZ);
		is_lower = (character >= CH_LA) && (character <= CH_LZ);
		if (is_num) begin
			dval = character - CH_0;
		end else if (is_upper) begin
			dval = character - OFS_UPPER;
		end else if (is_lower) begin
			dval = character - OFS_LOWER;
		end else begin
			dval = {2'b00, a2u_pkg::NO_DIGIT};
		end
		q_data.nul   = (character == 8'h00);
		q_data.ws    = ((character >= CH_TAB) && (character <= CH_CR)) || (character == CH_SPACE);
		q_data.plus  = (character == CH_PLUS);
		q_data.minus = (character == CH_MINUS);
		q_data.zero  = (character == CH_0);
		q_data.x     = (character == CH_LX) || (character == CH_UX);
		q_data.hex   = is_num || ((character >= CH_UA) && (character <= CH_UF)) ||
			((character >= CH_LA) && (character <= CH_LF));
		q_data.digit = dval[5:0];
	end

endmodule

/* sv/a2u_queue.sv */
// Short queue of classified characters between front and back.
module a2u_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  a2u_pkg::cls_t        push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output a2u_pkg::cls_t        head
);

	a2u_pkg::cls_t                   mem_q [a2u_pkg::QUEUE_DEPTH];
	logic [a2u_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [a2u_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [a2u_pkg::QCNT_BITS-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = (count_q == a2u_pkg::QCNT_BITS'(a2u_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* sv/a2u_back.sv */
// Back end: parse state machine, accumulator and result register.
module a2u_back #(
	parameter int unsigned VALUE_BITS    = 32,
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [5:0]       number_base,
	input  logic             q_valid,
	input  a2u_pkg::cls_t    q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      value,
	output logic [15:0]      end_index,
	output logic [1:0]       status
);

	localparam int unsigned VB = VALUE_BITS;
	localparam int unsigned PB = POSITION_BITS;
	localparam logic [PB-1:0] POS_ONE = {{(PB-1){1'b0}}, 1'b1};
	localparam logic [VB-1:0] VAL_ONE = {{(VB-1){1'b0}}, 1'b1};

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGNED,
		PH_ZERO,
		PH_ZERO_X,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [VB-1:0]   acc_q, acc_n;
	logic            ovf_q, ovf_n;
	logic            seen_q, seen_n;
	logic            neg_q, neg_n;
	logic [5:0]      abase_q, abase_n;
	logic [PB-1:0]   pos_q, pos_n;
	logic            out_valid_q;
	logic [31:0]     value_q;
	logic [15:0]     end_index_q;
	logic [1:0]      status_q;

	logic            out_free;
	logic            first;
	logic            base_bad;
	logic [5:0]      base_cur;
	logic            dc;
	logic [5:0]      dc_base;
	logic            do_fin;
	logic [PB-1:0]   fin_idx;
	logic            emit;
	logic [VB-1:0]   em_v;
	logic [PB-1:0]   em_i;
	logic [1:0]      em_s;
	logic [VB+5:0]   prod;
	logic [VB-1:0]   sat_v;
	logic [VB-1:0]   fin_v;
	logic [PB-1:0]   pos_m1;
	logic            pos_step;
	logic [VB+31:0]  v_ext;
	logic [PB+15:0]  i_ext;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = q_valid && out_free;
	assign first    = (phase_q == PH_WS) && (pos_q == '0);
	assign base_bad = (number_base == a2u_pkg::BASE_ONE) || (number_base > a2u_pkg::BASE_MAX);
	assign base_cur = first ? number_base : abase_q;
	assign pos_m1   = (pos_q == '0) ? '0 : (pos_q - POS_ONE);

	assign prod = ({6'b0, acc_q} * {{VB{1'b0}}, dc_base}) + {{VB{1'b0}}, q_head.digit};

	assign sat_v = ovf_q ? '1 : acc_q;
	assign fin_v = neg_q ? (~sat_v + VAL_ONE) : sat_v;

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		seen_n   = seen_q;
		neg_n    = neg_q;
		abase_n  = base_cur;
		pos_n    = pos_q;
		pos_step = 1'b1;
		dc       = 1'b0;
		dc_base  = base_cur;
		do_fin   = 1'b0;
		fin_idx  = pos_q;
		emit     = 1'b0;
		em_v     = '0;
		em_i     = '0;
		em_s     = a2u_pkg::ST_OK;

		if (first && base_bad) begin
			// report at once, then drop the rest of the string
			emit     = 1'b1;
			em_s     = a2u_pkg::ST_BAD_BASE;
			pos_step = 1'b0;
			if (q_head.nul) begin
				abase_n = '0;
			end else begin
				phase_n = PH_DONE;
				pos_n   = POS_ONE;
			end
		end else if (q_head.nul) begin
			pos_step = 1'b0;
			case (phase_q)
				PH_WS, PH_SIGNED, PH_ZERO, PH_DIGITS: begin
					do_fin = 1'b1;
				end
				PH_ZERO_X: begin
					do_fin  = 1'b1;
					fin_idx = pos_m1;
				end
				default: begin
				end
			endcase
		end else begin
			case (phase_q)
				PH_WS, PH_SIGNED: begin
					if ((phase_q == PH_WS) && q_head.ws) begin
						phase_n = PH_WS;
					end else if ((phase_q == PH_WS) && q_head.plus) begin
						phase_n = PH_SIGNED;
					end else if ((phase_q == PH_WS) && q_head.minus) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGNED;
					end else if (q_head.zero &&
						((base_cur == a2u_pkg::BASE_AUTO) || (base_cur == a2u_pkg::BASE_HEX))) begin
						seen_n  = 1'b1;
						acc_n   = '0;
						phase_n = PH_ZERO;
					end else begin
						dc      = 1'b1;
						dc_base = (base_cur == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_DEC : base_cur;
					end
				end
				PH_ZERO: begin
					if (q_head.x) begin
						phase_n = PH_ZERO_X;
					end else begin
						dc      = 1'b1;
						dc_base = (abase_q == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_OCT : abase_q;
					end
				end
				PH_ZERO_X: begin
					if (q_head.hex) begin
						dc      = 1'b1;
						dc_base = a2u_pkg::BASE_HEX;
						acc_n   = '0;
					end else begin
						phase_n = PH_DONE;
						do_fin  = 1'b1;
						fin_idx = pos_m1;
					end
				end
				PH_DIGITS: begin
					dc = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (dc) begin
			abase_n = dc_base;
			if (q_head.digit < dc_base) begin
				seen_n  = 1'b1;
				phase_n = PH_DIGITS;
				if (ovf_q || (prod[VB+5:VB] != '0)) begin
					ovf_n = 1'b1;
				end else begin
					acc_n = prod[VB-1:0];
				end
			end else begin
				phase_n = PH_DONE;
				do_fin  = 1'b1;
			end
		end

		if (do_fin) begin
			emit = 1'b1;
			if (!seen_q) begin
				em_s = a2u_pkg::ST_NO_DIGITS;
			end else begin
				em_v = fin_v;
				em_i = fin_idx;
				em_s = ovf_q ? a2u_pkg::ST_OVERFLOW : a2u_pkg::ST_OK;
			end
		end

		if (pos_step && (pos_q != '1)) begin
			pos_n = pos_q + POS_ONE;
		end

		// zero byte readies the next string
		if (q_head.nul) begin
			phase_n = PH_WS;
			acc_n   = '0;
			ovf_n   = 1'b0;
			seen_n  = 1'b0;
			neg_n   = 1'b0;
			abase_n = '0;
			pos_n   = '0;
		end
	end

	assign v_ext = {32'b0, em_v};
	assign i_ext = {16'b0, em_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WS;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			seen_q      <= 1'b0;
			neg_q       <= 1'b0;
			abase_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			end_index_q <= '0;
			status_q    <= a2u_pkg::ST_OK;
		end else begin
			if (q_pop) begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				seen_q  <= seen_n;
				neg_q   <= neg_n;
				abase_q <= abase_n;
				pos_q   <= pos_n;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
				value_q     <= v_ext[31:0];
				end_index_q <= i_ext[15:0];
				status_q    <= em_s;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign end_index = end_index_q;
	assign status    = status_q;

endmodule

/* tb/ascii_to_unsigned_converter_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the streaming ASCII to unsigned converter.
module ascii_to_unsigned_converter_tb;

	localparam int unsigned RESET_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned RANDOM_ITEMS = 1850;
	localparam int unsigned NUM_PHASES   = 12;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_LEADING, PH_SIGN, PH_ZERO, PH_ZERO_X, PH_NUMBER, PH_TAIL
	} parse_phase_t;

	typedef struct packed {
		logic [31:0] value;
		logic [15:0] end_index;
		logic [1:0]  status;
	} conv_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  character = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] value;
	logic [15:0] end_index;
	logic [1:0]  status;
	logic        cfg_we    = 1'b0;
	logic [5:0]  cfg_wdata = 6'd0;

	ascii_to_unsigned_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.end_index (end_index),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Predicted converter state
	logic [5:0]   base_reg  = a2u_pkg::BASE_RESET;
	parse_phase_t str_phase = PH_LEADING;
	logic [31:0]  acc       = 32'd0;
	logic         ovf       = 1'b0;
	logic         seen      = 1'b0;
	logic         neg       = 1'b0;
	logic [5:0]   str_base  = 6'd0;
	logic [15:0]  str_pos   = 16'd0;

	logic [7:0]   char_q[$];
	conv_result_t pending_conversions[$];
	conv_result_t oldest;

	logic        req_taken       = 1'b0;
	int          send_gap        = 0;
	int          stall_left      = 0;
	bit          sender_idling   = 1'b0;
	bit          receiver_idling = 1'b0;
	int unsigned errors          = 0;
	int unsigned cycles          = 0;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
		errors++;
	endtask

	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd63;
		if (c >= "0" && c <= "9")
			d = c - "0";
		else if (c >= "A" && c <= "Z")
			d = c - "A" + 8'd10;
		else if (c >= "a" && c <= "z")
			d = c - "a" + 8'd10;
		return (d == 8'd63) ? a2u_pkg::NO_DIGIT : d[5:0];
	endfunction

	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	task automatic restart_string();
		str_phase = PH_LEADING;
		acc       = 32'd0;
		ovf       = 1'b0;
		seen      = 1'b0;
		neg       = 1'b0;
		str_base  = 6'd0;
		str_pos   = 16'd0;
	endtask

	task automatic log_result(input logic [31:0] v, input logic [15:0] idx,
			input logic [1:0] st);
		conv_result_t r;
		r.value     = v;
		r.end_index = idx;
		r.status    = st;
		pending_conversions.push_back(r);
	endtask

	task automatic add_digit(input logic [5:0] d);
		logic [63:0] radix;
		logic [63:0] sum;
		radix = (str_base >= 6'd2 && str_base <= a2u_pkg::BASE_MAX) ? {58'd0, str_base}
		                                                            : {58'd0, a2u_pkg::BASE_DEC};
		sum = {32'd0, acc} * radix + {58'd0, d};
		// saturate once the product no longer fits
		if (ovf || sum[63:32] != 32'd0)
			ovf = 1'b1;
		else
			acc = sum[31:0];
		seen = 1'b1;
	endtask

	task automatic close_number(input logic [15:0] idx);
		logic [31:0] v;
		if (!seen) begin
			log_result(32'd0, 16'd0, a2u_pkg::ST_NO_DIGITS);
		end else begin
			v = ovf ? 32'hFFFF_FFFF : acc;
			if (neg)
				v = -v;
			log_result(v, idx, ovf ? a2u_pkg::ST_OVERFLOW : a2u_pkg::ST_OK);
		end
	endtask

	task automatic take_digit(input logic [7:0] c);
		logic [5:0] d;
		d = digit_value(c);
		if (d < str_base) begin
			add_digit(d);
			str_phase = PH_NUMBER;
		end else begin
			str_phase = PH_TAIL;
			close_number(str_pos);
		end
	endtask

	task automatic start_number(input logic [7:0] c);
		if (c == "0" && (str_base == a2u_pkg::BASE_AUTO || str_base == a2u_pkg::BASE_HEX)) begin
			seen      = 1'b1;
			acc       = 32'd0;
			str_phase = PH_ZERO;
		end else begin
			if (str_base == a2u_pkg::BASE_AUTO)
				str_base = a2u_pkg::BASE_DEC;
			take_digit(c);
		end
	endtask

	// Advance the predicted parser by one accepted character.
	task automatic convert_char(input logic [7:0] c);
		bit bad_base;
		bad_base = 1'b0;
		if (str_phase == PH_LEADING && str_pos == 16'd0) begin
			str_base = base_reg;
			if (str_base == a2u_pkg::BASE_ONE || str_base > a2u_pkg::BASE_MAX) begin
				bad_base = 1'b1;
				log_result(32'd0, 16'd0, a2u_pkg::ST_BAD_BASE);
				if (c == CH_NUL) begin
					restart_string();
				end else begin
					str_phase = PH_TAIL;
					str_pos   = 16'd1;
				end
			end
		end
		if (!bad_base && c == CH_NUL) begin
			case (str_phase)
				PH_LEADING, PH_SIGN, PH_ZERO, PH_NUMBER: close_number(str_pos);
				PH_ZERO_X: close_number(str_pos != 16'd0 ? str_pos - 16'd1 : 16'd0);
				default: ;
			endcase
			restart_string();
		end else if (!bad_base) begin
			case (str_phase)
				PH_LEADING: begin
					if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
					end else if (c == "+") begin
						str_phase = PH_SIGN;
					end else if (c == "-") begin
						neg       = 1'b1;
						str_phase = PH_SIGN;
					end else begin
						start_number(c);
					end
				end
				PH_SIGN: start_number(c);
				PH_ZERO: begin
					if (c == "x" || c == "X") begin
						str_phase = PH_ZERO_X;
					end else begin
						if (str_base == a2u_pkg::BASE_AUTO)
							str_base = a2u_pkg::BASE_OCT;
						take_digit(c);
					end
				end
				PH_ZERO_X: begin
					if (is_hex_char(c)) begin
						str_base = a2u_pkg::BASE_HEX;
						acc      = 32'd0;
						take_digit(c);
					end else begin
						// prefix with no hex digit: number ends at the 'x'
						str_phase = PH_TAIL;
						close_number(str_pos != 16'd0 ? str_pos - 16'd1 : 16'd0);
					end
				end
				PH_NUMBER: take_digit(c);
				default: ;
			endcase
			if (str_pos != 16'hFFFF)
				str_pos++;
		end
	endtask

	// Check results first, then predict, so an early result cannot match a fresh entry.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_conversions.size() == 0) begin
					report_mismatch("unexpected result value", value, 32'd0);
				end else begin
					oldest = pending_conversions.pop_front();
					if (value !== oldest.value)
						report_mismatch("value", value, oldest.value);
					if (end_index !== oldest.end_index)
						report_mismatch("end_index", {16'd0, end_index}, {16'd0, oldest.end_index});
					if (status !== oldest.status)
						report_mismatch("status", {30'd0, status}, {30'd0, oldest.status});
				end
			end
			if (in_valid && in_ready)
				convert_char(character);
			req_taken <= in_valid && in_ready;
		end
	end

	// Character driver: hold a request until taken, then advance or idle.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (char_q.size() != 0 && sender_idling && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (char_q.size() != 0) begin
				in_valid  <= 1'b1;
				character <= char_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver with random stall bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ascii_to_unsigned_converter_tb: FAIL");
			$finish;
		end
	end

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			char_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] digit_char(input int d);
		logic [7:0] c;
		if (d < 10)
			c = 8'("0" + d);
		else if ($urandom_range(0, 1) == 0)
			c = 8'("a" + d - 10);
		else
			c = 8'("A" + d - 10);
		return c;
	endfunction

	task automatic push_number(input longint unsigned v, input int radix);
		logic [7:0] digs[$];
		do begin
			digs.push_front(digit_char(int'(v % radix)));
			v = v / radix;
		end while (v != 0);
		foreach (digs[i])
			char_q.push_back(digs[i]);
	endtask

	task automatic push_tail();
		repeat ($urandom_range(0, 4))
			char_q.push_back(8'($urandom_range(1, 255)));
	endtask

	// One random string; returns how many characters it queued.
	task automatic random_string(output int n_items);
		int          start_size;
		int          kind;
		int          radix;
		int          b;
		longint unsigned v;
		bit          bad_base;
		start_size = char_q.size();
		bad_base   = (base_reg == a2u_pkg::BASE_ONE || base_reg > a2u_pkg::BASE_MAX);
		kind       = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(0, 8))
				char_q.push_back(8'($urandom_range(1, 255)));
		end else if (kind == 1) begin
			case ($urandom_range(0, 3))
				0: push_text($urandom_range(0, 1) ? "+" : "-");
				1: begin
					push_text($urandom_range(0, 1) ? "0x" : "0X");
					char_q.push_back($urandom_range(0, 1) ? 8'($urandom_range("g", "z"))
					                                      : CH_SPACE);
					push_tail();
				end
				2: push_text("0x");
				default: push_text("+-5");
			endcase
		end else begin
			repeat ($urandom_range(0, 2)) begin
				b = $urandom_range(9, 14);
				char_q.push_back(b == 14 ? CH_SPACE : 8'(b));
			end
			case ($urandom_range(0, 3))
				0: push_text("+");
				1: push_text("-");
				default: ;
			endcase
			radix = (bad_base || base_reg == a2u_pkg::BASE_AUTO) ? 10 : int'(base_reg);
			if ((base_reg == a2u_pkg::BASE_AUTO || base_reg == a2u_pkg::BASE_HEX) &&
					$urandom_range(0, 1)) begin
				push_text($urandom_range(0, 1) ? "0x" : "0X");
				radix = 16;
			end else if (base_reg == a2u_pkg::BASE_AUTO && $urandom_range(0, 1)) begin
				push_text("0");
				radix = 8;
			end else if (base_reg != a2u_pkg::BASE_AUTO && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3))
					push_text("0");
			end
			case ($urandom_range(0, 5))
				0: v = 64'($urandom_range(0, 40));
				1: v = 64'($urandom());
				2: v = 64'hFFFF_FFFF - $urandom_range(0, 3);
				3: v = 64'h1_0000_0000 + $urandom_range(0, 3);
				4: v = {$urandom(), $urandom()};
				default: v = 64'($urandom() >> $urandom_range(0, 31));
			endcase
			push_number(v, radix);
			case ($urandom_range(0, 3))
				1: begin
					char_q.push_back(radix < 36 ? digit_char(radix) : "!");
					push_tail();
				end
				2: begin
					char_q.push_back(8'($urandom_range(1, 255)));
					push_tail();
				end
				default: ;
			endcase
		end
		char_q.push_back(CH_NUL);
		n_items = char_q.size() - start_size;
	endtask

	task automatic drain();
		@(posedge clk);
		while (char_q.size() != 0 || in_valid || pending_conversions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [5:0] b);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		base_reg = b;
		@(posedge clk);
	endtask

	function automatic logic [5:0] base_for_phase(input int p);
		case (p)
			0:       return a2u_pkg::BASE_HEX;
			1:       return a2u_pkg::BASE_AUTO;
			2:       return a2u_pkg::BASE_ONE;
			3:       return 6'd2;
			4:       return a2u_pkg::BASE_OCT;
			5:       return 6'd37;
			6:       return a2u_pkg::BASE_MAX;
			7:       return 6'd63;
			8:       return 6'd7;
			9:       return a2u_pkg::BASE_HEX;
			10:      return a2u_pkg::BASE_AUTO;
			default: return a2u_pkg::BASE_DEC;
		endcase
	endfunction

	initial begin
		int budget;
		int done_items;
		int n;

		// Directed strings at the reset base
		char_q.push_back(CH_NUL);
		push_text("\t+7z");
		char_q.push_back(CH_NUL);
		push_text("-0");
		char_q.push_back(CH_NUL);
		char_q.push_back(8'hFF);
		char_q.push_back(CH_NUL);
		push_text("99999999999");
		char_q.push_back(CH_NUL);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		budget = RANDOM_ITEMS / NUM_PHASES;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			sender_idling   = (p != NUM_PHASES - 1) && $urandom_range(0, 3) != 0;
			receiver_idling = (p != NUM_PHASES - 1) && $urandom_range(0, 3) != 0;
			write_base(base_for_phase(p));
			if (base_reg == a2u_pkg::BASE_AUTO || base_reg == a2u_pkg::BASE_HEX) begin
				push_text("0x");
				char_q.push_back(CH_NUL);
				push_text("0xg");
				char_q.push_back(CH_NUL);
				push_text("-0X1f");
				char_q.push_back(CH_NUL);
			end
			done_items = 0;
			while (done_items < budget) begin
				random_string(n);
				done_items += n;
				if (p == 4 && done_items >= budget / 2 && done_items - n < budget / 2) begin
					// hold the sender mid-string until every result is back
					push_text("  -12");
					drain();
					push_text("34");
					char_q.push_back(CH_NUL);
				end
			end
		end
		drain();
		if (errors == 0)
			$display("ascii_to_unsigned_converter_tb: PASS");
		else
			$display("ascii_to_unsigned_converter_tb: FAIL");
		$finish;
	end

endmodule
